// File: rtl/kpsd_pkg.sv
// Package: shared constants, types and key code table for the keypad scanner.
`timescale 1ns / 1ps
package kpsd_pkg;

  localparam int NUM_ROWS    = 4;
  localparam int NUM_COLUMNS = 3;
  localparam int IN_ROWS     = 4;
  localparam int COL_W       = (NUM_COLUMNS > 1) ? $clog2(NUM_COLUMNS) : 1;
  localparam int ROW_W       = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
  localparam int CODE_W      = 7;
  localparam int SCAN_W      = 2;
  localparam int CNT_W       = 8;

  localparam logic [CNT_W-1:0] TICKS_RESET = CNT_W'(20);
  localparam logic [CODE_W-1:0] CODE_NONE  = '0;

  typedef struct packed {
    logic              key_valid;
    logic [CODE_W-1:0] key_code;
  } kpsd_result_t;

  // ASCII code of the key at (col, row); keys outside the 3x4 grid give none
  function automatic logic [CODE_W-1:0] code_of(input logic [COL_W-1:0] col,
                                                input logic [ROW_W-1:0] row);
    logic [7:0] c;
    c = 8'h00;
    if ((32'(col) < 3) && (32'(row) < 4)) begin
      case ({2'(col), 2'(row)})
        4'b0000: c = "3";
        4'b0001: c = "6";
        4'b0010: c = "9";
        4'b0011: c = "#";
        4'b0100: c = "2";
        4'b0101: c = "5";
        4'b0110: c = "8";
        4'b0111: c = "0";
        4'b1000: c = "1";
        4'b1001: c = "4";
        4'b1010: c = "7";
        4'b1011: c = "*";
        default: c = 8'h00;
      endcase
    end
    return c[CODE_W-1:0];
  endfunction

endpackage

// File: rtl/kpsd_lane.sv
// One row lane: two-sample history per column and 0,1,1 press detection.
`timescale 1ns / 1ps
module kpsd_lane (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       advance_i,
  input  logic [kpsd_pkg::COL_W-1:0] col_i,
  input  logic                       now_i,
  output logic                       press_o
);
  import kpsd_pkg::*;

  logic [1:0] hist_q [NUM_COLUMNS];
  logic [1:0] hist_d [NUM_COLUMNS];
  logic [1:0] cur;

  assign cur     = hist_q[col_i];
  assign press_o = now_i & cur[0] & ~cur[1];

  always_comb begin
    for (int c = 0; c < NUM_COLUMNS; c++) begin
      hist_d[c] = hist_q[c];
    end
    if (advance_i) begin
      hist_d[col_i] = {cur[0], now_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < NUM_COLUMNS; c++) begin
        hist_q[c] <= 2'b00;
      end
    end else begin
      for (int c = 0; c < NUM_COLUMNS; c++) begin
        hist_q[c] <= hist_d[c];
      end
    end
  end

endmodule

// File: rtl/kpsd_merge.sv
// Merge stage: highest pressing row wins, key code looked up from the table.
`timescale 1ns / 1ps
module kpsd_merge (
  input  logic [kpsd_pkg::NUM_ROWS-1:0] press_i,
  input  logic [kpsd_pkg::COL_W-1:0]    col_i,
  output kpsd_pkg::kpsd_result_t        result_o
);
  import kpsd_pkg::*;

  always_comb begin
    result_o.key_valid = 1'b0;
    result_o.key_code  = CODE_NONE;
    for (int r = 0; r < NUM_ROWS; r++) begin
      if (press_i[r]) begin
        result_o.key_valid = 1'b1;
        result_o.key_code  = code_of(col_i, ROW_W'(r));
      end
    end
  end

endmodule

// File: rtl/keypad_scan_debounce_core.sv
// Top level: keypad column scanner, per-row debounce lanes and tick divider.
//
// Usage: each input transaction on row_levels_i is one scan tick, carrying
// the row levels sampled while the current column is driven. Every input
// transaction yields exactly one output transaction: key_valid_o/key_code_o
// flag a new debounced press (highest row wins), scan_column_o names the
// column to drive next (1 to 3), tick_count_o/tenth_tick_o give the divided
// tick counter. Both channels use valid/ready.
// Output valid follows in the cycle after an input transaction is accepted; one
// tick per cycle is sustained while the receiver is ready, set by the single
// output register, which is refilled in the same cycle that its contents are taken.
// cfg_we_i/cfg_wdata_i write ticks_per_tenth (reset 20) with no wait; write
// only while idle. A value of 0 gives a period of 256 ticks.
// Reset clears the column phase (first tick credits column one), all key
// histories and the tick counter; the output register is empty.
// When the receiver stalls the result is held and in_ready_o drops until it
// is taken; the scan state only advances on accepted ticks.
`timescale 1ns / 1ps
module keypad_scan_debounce_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [kpsd_pkg::CNT_W-1:0]  cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [kpsd_pkg::IN_ROWS-1:0] row_levels_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        key_valid_o,
  output logic [kpsd_pkg::CODE_W-1:0] key_code_o,
  output logic [kpsd_pkg::SCAN_W-1:0] scan_column_o,
  output logic [kpsd_pkg::CNT_W-1:0]  tick_count_o,
  output logic                        tenth_tick_o
);
  import kpsd_pkg::*;

  logic                accept;
  logic [CNT_W-1:0]    ticks_q;
  logic [COL_W-1:0]    phase_q, phase_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d, cnt_inc;
  logic                tenth;
  logic [NUM_ROWS-1:0] press;
  kpsd_result_t        result;
  logic [COL_W:0]      scan_wide;
  logic                out_valid_q;
  kpsd_result_t        res_q;
  logic [SCAN_W-1:0]   scan_q;
  logic [CNT_W-1:0]    cnt_out_q;
  logic                tenth_q;

  assign in_ready_o = ~out_valid_q | out_ready_i;
  assign accept     = in_valid_i & in_ready_o;

  assign cnt_inc = cnt_q + CNT_W'(1);
  assign tenth   = (cnt_inc == ticks_q);
  assign cnt_d   = tenth ? '0 : cnt_inc;

  assign phase_d   = (32'(phase_q) == NUM_COLUMNS - 1) ? '0 : phase_q + COL_W'(1);
  assign scan_wide = {1'b0, phase_d} + (COL_W+1)'(1);

  for (genvar r = 0; r < NUM_ROWS; r++) begin : g_lane
    logic now;
    if (r < IN_ROWS) begin : g_in
      assign now = row_levels_i[r];
    end else begin : g_zero
      assign now = 1'b0;
    end
    kpsd_lane u_lane (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .advance_i (accept),
      .col_i     (phase_q),
      .now_i     (now),
      .press_o   (press[r])
    );
  end

  kpsd_merge u_merge (
    .press_i  (press),
    .col_i    (phase_q),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ticks_q     <= TICKS_RESET;
      phase_q     <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        ticks_q <= cfg_wdata_i;
      end
      if (accept) begin
        phase_q     <= phase_d;
        cnt_q       <= cnt_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q     <= result;
      scan_q    <= scan_wide[SCAN_W-1:0];
      cnt_out_q <= cnt_d;
      tenth_q   <= tenth;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign key_valid_o   = res_q.key_valid;
  assign key_code_o    = res_q.key_code;
  assign scan_column_o = scan_q;
  assign tick_count_o  = cnt_out_q;
  assign tenth_tick_o  = tenth_q;

  a_accept_fills : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_o)
    else $error("accepted tick produced no result");

  a_key_has_code : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && key_valid_o |-> key_code_o != CODE_NONE)
    else $error("press reported without key code");

  a_tenth_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && tenth_tick_o |-> tick_count_o == '0)
    else $error("tenth pulse with non-zero tick count");

  a_scan_col : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> scan_column_o != '0)
    else $error("scan column zero");

endmodule

// File: sim/testbench.sv
// Testbench for the keypad scanner: directed table, then randomised scans checked by a predictor.
`timescale 1ns / 1ps
module testbench;
  import kpsd_pkg::*;

  localparam int LIMIT   = 200000;
  localparam int HOLD    = 200;
  localparam int NPHASES = 9;

  typedef struct packed {
    logic              kv;
    logic [CODE_W-1:0] kc;
    logic [SCAN_W-1:0] col;
    logic [CNT_W-1:0]  cnt;
    logic              tt;
  } scan_result_t;

  typedef struct packed {
    logic [IN_ROWS-1:0] rows;
    logic               typed;
    scan_result_t       res;
  } scan_step_t;

  localparam logic [CODE_W-1:0] KEY_CODES [3][4] = '{
    '{7'h33, 7'h36, 7'h39, 7'h23},
    '{7'h32, 7'h35, 7'h38, 7'h30},
    '{7'h31, 7'h34, 7'h37, 7'h2A}
  };

  // typed rows: after reset, full-row press per column, single-row press with tenth wrap
  localparam scan_step_t DIRECTED [24] = '{
    '{4'h0, 1'b1, '{1'b0, 7'h00, 2'd2, 8'd1, 1'b0}},
    '{4'h0, 1'b1, '{1'b0, 7'h00, 2'd3, 8'd2, 1'b0}},
    '{4'h0, 1'b1, '{1'b0, 7'h00, 2'd1, 8'd3, 1'b0}},
    '{4'hF, 1'b0, '0},
    '{4'hF, 1'b0, '0},
    '{4'hF, 1'b0, '0},
    '{4'hF, 1'b1, '{1'b1, 7'h23, 2'd2, 8'd7, 1'b0}},
    '{4'hF, 1'b1, '{1'b1, 7'h30, 2'd3, 8'd8, 1'b0}},
    '{4'hF, 1'b1, '{1'b1, 7'h2A, 2'd1, 8'd9, 1'b0}},
    '{4'hF, 1'b0, '0},
    '{4'hF, 1'b0, '0},
    '{4'hF, 1'b0, '0},
    '{4'h0, 1'b0, '0},
    '{4'h0, 1'b0, '0},
    '{4'h0, 1'b0, '0},
    '{4'h1, 1'b0, '0},
    '{4'h1, 1'b0, '0},
    '{4'h1, 1'b0, '0},
    '{4'h1, 1'b1, '{1'b1, 7'h33, 2'd2, 8'd19, 1'b0}},
    '{4'h1, 1'b1, '{1'b1, 7'h32, 2'd3, 8'd0, 1'b1}},
    '{4'h1, 1'b1, '{1'b1, 7'h31, 2'd1, 8'd1, 1'b0}},
    '{4'hA, 1'b0, '0},
    '{4'h5, 1'b0, '0},
    '{4'h6, 1'b0, '0}
  };

  logic               clk_i;
  logic               rst_ni     = 1'b0;
  logic               cfg_we     = 1'b0;
  logic [CNT_W-1:0]   cfg_wdata  = '0;
  logic               in_valid   = 1'b0;
  logic [IN_ROWS-1:0] row_levels = '0;
  logic               out_ready  = 1'b0;
  logic               in_ready;
  logic               out_valid;
  logic               key_valid;
  logic [CODE_W-1:0]  key_code;
  logic [SCAN_W-1:0]  scan_column;
  logic [CNT_W-1:0]   tick_count;
  logic               tenth_tick;

  keypad_scan_debounce_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .row_levels_i  (row_levels),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .key_valid_o   (key_valid),
    .key_code_o    (key_code),
    .scan_column_o (scan_column),
    .tick_count_o  (tick_count),
    .tenth_tick_o  (tenth_tick)
  );

  // predictor state
  int unsigned        scan_phase_q = 0;
  logic [1:0]         key_hist_q [12] = '{default: '0};
  logic [CNT_W-1:0]   tick_cnt_q = '0;
  logic [CNT_W-1:0]   divide_q = TICKS_RESET;
  logic [IN_ROWS-1:0] held_rows [3] = '{default: '0};

  scan_result_t pending_scans [$];
  scan_result_t want;
  int           mismatches = 0;
  bit           hold_off = 1'b0;
  bit           send_burst = 1'b0;
  bit           recv_burst = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic scan_result_t scan_tick(input logic [IN_ROWS-1:0] rows);
    scan_result_t res;
    int unsigned col;
    logic [1:0] h;
    res = '0;
    tick_cnt_q = tick_cnt_q + 1'b1;
    if (tick_cnt_q == divide_q) begin
      tick_cnt_q = '0;
      res.tt = 1'b1;
    end
    col = scan_phase_q;
    scan_phase_q = (col + 1 >= 3) ? 0 : col + 1;
    for (int r = 0; r < 4; r++) begin
      h = key_hist_q[col*4 + r];
      key_hist_q[col*4 + r] = {h[0], rows[r]};
      if (rows[r] && h[0] && !h[1]) begin
        res.kv = 1'b1;
        res.kc = KEY_CODES[col][r];
      end
    end
    res.col = SCAN_W'((col + 1) % 3 + 1);
    res.cnt = tick_cnt_q;
    return res;
  endfunction

  // mostly held patterns per column so that presses debounce, with some noise
  function automatic logic [IN_ROWS-1:0] pick_rows();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 15) return IN_ROWS'($urandom);
    if (roll < 35) begin
      case ($urandom_range(0, 3))
        0:       held_rows[scan_phase_q] = '0;
        1:       held_rows[scan_phase_q] = IN_ROWS'($urandom);
        default: held_rows[scan_phase_q] = IN_ROWS'(1 << $urandom_range(0, 3));
      endcase
    end
    return held_rows[scan_phase_q];
  endfunction

  task automatic send_tick(input logic [IN_ROWS-1:0] rows, input logic typed,
                           input scan_result_t typed_res);
    int gap;
    scan_result_t res;
    if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
    gap = send_burst ? 0 : $urandom_range(0, 4);
    repeat (gap) begin
      @(negedge clk_i);
      in_valid <= 1'b0;
    end
    @(negedge clk_i);
    in_valid   <= 1'b1;
    row_levels <= rows;
    do @(posedge clk_i); while (!in_ready);
    res = scan_tick(rows);
    pending_scans.push_back(typed ? typed_res : res);
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (pending_scans.size() != 0) @(negedge clk_i);
  endtask

  task automatic set_divide(input logic [CNT_W-1:0] value);
    drain_results();
    repeat (2) @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    divide_q = value;
  endtask

  task automatic check_field(input string name, input int unsigned exp_v,
                             input int unsigned act_v);
    if (exp_v != act_v) begin
      mismatches++;
      $display("%0t: %s expected %0d, got %0d", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid && out_ready) begin
      if (pending_scans.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result transaction, got key %0d code %0h", $time,
                 key_valid, key_code);
      end else begin
        want = pending_scans.pop_front();
        check_field("key_valid", want.kv, key_valid);
        check_field("key_code", want.kc, key_code);
        check_field("scan_column", want.col, scan_column);
        check_field("tick_count", want.cnt, tick_count);
        check_field("tenth_tick", want.tt, tenth_tick);
      end
    end
  end

  initial begin
    int stall;
    @(posedge rst_ni);
    forever begin
      if (hold_off) begin
        hold_off = 1'b0;
        for (int c = 0; c < HOLD; c++) begin
          @(negedge clk_i);
          out_ready <= 1'b0;
        end
      end
      if ($urandom_range(0, 39) == 0) recv_burst = !recv_burst;
      stall = recv_burst ? 0 : $urandom_range(0, 4);
      repeat (stall) begin
        @(negedge clk_i);
        out_ready <= 1'b0;
      end
      @(negedge clk_i);
      out_ready <= 1'b1;
      do @(posedge clk_i); while (!out_valid);
    end
  end

  initial begin
    int cycles;
    cycles = 0;
    while (cycles < LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("testbench NOT OK");
    $finish;
  end

  initial begin
    int unsigned phase_len [NPHASES];
    logic [CNT_W-1:0] fixed_div [4];
    phase_len = '{100, 300, 300, 200, 110, 110, 110, 110, 110};
    fixed_div = '{8'd1, 8'd255, 8'd0, 8'd3};
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (DIRECTED[i]) send_tick(DIRECTED[i].rows, DIRECTED[i].typed, DIRECTED[i].res);

    for (int p = 0; p < NPHASES; p++) begin
      set_divide(p < 4 ? fixed_div[p] : CNT_W'($urandom_range(0, 255)));
      for (int n = 0; n < phase_len[p]; n++) begin
        if (p == 0 && n == 50) hold_off = 1'b1;
        if (p == 1 && n == 150) drain_results();
        send_tick(pick_rows(), 1'b0, '0);
      end
    end

    drain_results();
    repeat (4) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/kpsd_pkg.sv
rtl/kpsd_lane.sv
rtl/kpsd_merge.sv
rtl/keypad_scan_debounce_core.sv
sim/testbench.sv
